/* rtl/qat_pkg.sv */
`default_nettype none

package qat_pkg;

   // Most results that one request can cause.
   localparam int MaxResults = 4;

   // Default number of result bundles held between front and back.
   localparam int QueueDepth = 4;

   // One result: a token byte or a mark.
   typedef struct packed {
      logic [7:0] token_byte;
      logic       token_byte_valid;
      logic       token_done;
      logic       line_done;
      logic       parse_error;
   } qat_result_type;

   // All results of one request; count runs from 1 to MaxResults.
   typedef struct packed {
      logic [$clog2(MaxResults+1)-1:0]     count;
      qat_result_type [MaxResults-1:0]     results;
   } qat_bundle_type;

   // Write side of the result queue.
   typedef struct packed {
      logic           valid;
      qat_bundle_type bundle;
   } qat_push_type;

   // Read side of the result queue.
   typedef struct packed {
      logic           valid;
      qat_bundle_type bundle;
   } qat_head_type;

endpackage

`default_nettype wire

/* rtl/qat_front.sv */
`default_nettype none

module qat_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  queue_full,
   output qat_pkg::qat_push_type      push
);

   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChTab       = 8'h09;
   localparam logic [7:0] ChNewline   = 8'h0A;
   localparam logic [7:0] ChVtab      = 8'h0B;
   localparam logic [7:0] ChFormfeed  = 8'h0C;
   localparam logic [7:0] ChReturn    = 8'h0D;
   localparam logic [7:0] ChBackspace = 8'h08;
   localparam logic [7:0] ChBell      = 8'h07;
   localparam logic [7:0] ChDquote    = 8'h22;
   localparam logic [7:0] ChSquote    = 8'h27;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChLowerX    = 8'h78;
   localparam logic [7:0] ChLowerN    = 8'h6E;
   localparam logic [7:0] ChLowerR    = 8'h72;
   localparam logic [7:0] ChLowerT    = 8'h74;
   localparam logic [7:0] ChLowerB    = 8'h62;
   localparam logic [7:0] ChLowerA    = 8'h61;
   localparam int         CountWidth  = $clog2(qat_pkg::MaxResults+1);
   localparam int         SlotWidth   = $clog2(qat_pkg::MaxResults);

   typedef enum logic [5:0] {
      MODE_BETWEEN = 6'b000001,
      MODE_PLAIN   = 6'b000010,
      MODE_DQ      = 6'b000100,
      MODE_SQ      = 6'b001000,
      MODE_CLOSED  = 6'b010000,
      MODE_ERROR   = 6'b100000
   } mode_type;

   typedef enum logic [3:0] {
      ESC_NONE  = 4'b0001,
      ESC_SLASH = 4'b0010,
      ESC_X     = 4'b0100,
      ESC_HEX1  = 4'b1000
   } esc_type;

   mode_type    mode_ff, mode_in;
   esc_type     esc_ff, esc_in;
   logic [7:0]  first_hex_ff, first_hex_in;

   logic [7:0]                                  ch;
   logic                                        accept;
   logic                                        do_plain;
   logic                                        do_fresh;
   logic [7:0]                                  quote_ch;
   logic [CountWidth-1:0]                       n_res;
   qat_pkg::qat_result_type [qat_pkg::MaxResults-1:0] res;

   function automatic logic is_sep(input logic [7:0] c);
      is_sep = (c == ChSpace) || (c == ChTab) || (c == ChNewline) ||
               (c == ChReturn) || (c == ChVtab) || (c == ChFormfeed);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
      hex_val = v[3:0];
   endfunction

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      case (c)
         ChLowerN: escape_map = ChNewline;
         ChLowerR: escape_map = ChReturn;
         ChLowerT: escape_map = ChTab;
         ChLowerB: escape_map = ChBackspace;
         ChLowerA: escape_map = ChBell;
         default:  escape_map = c;
      endcase
   endfunction

   function automatic qat_pkg::qat_result_type mk_byte(input logic [7:0] b);
      mk_byte = '{token_byte: b, token_byte_valid: 1'b1, token_done: 1'b0,
                  line_done: 1'b0, parse_error: 1'b0};
   endfunction

   function automatic qat_pkg::qat_result_type mk_mark(input logic td, input logic ld,
                                                       input logic err);
      mk_mark = '{token_byte: 8'd0, token_byte_valid: 1'b0, token_done: td,
                  line_done: ld, parse_error: err};
   endfunction

   assign ch         = req_tdata;
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign quote_ch   = (mode_ff == MODE_SQ) ? ChSquote : ChDquote;

   // Decode one request into its list of results and the next scan state.
   always_comb begin
      mode_in      = mode_ff;
      esc_in       = esc_ff;
      first_hex_in = first_hex_ff;
      do_plain     = 1'b0;
      do_fresh     = 1'b0;
      n_res        = '0;
      res          = '0;

      if (req_tuser) begin
         case (mode_ff)
            MODE_PLAIN: begin
               do_plain = 1'b1;
            end
            MODE_DQ: begin
               case (esc_ff)
                  ESC_SLASH: begin
                     if (ch == ChLowerX) begin
                        esc_in = ESC_X;
                     end else begin
                        esc_in = ESC_NONE;
                        res[n_res[SlotWidth-1:0]] = mk_byte(escape_map(ch));
                        n_res = n_res + 1'b1;
                     end
                  end
                  ESC_X: begin
                     if (is_hex(ch)) begin
                        first_hex_in = ch;
                        esc_in       = ESC_HEX1;
                     end else begin
                        esc_in = ESC_NONE;
                        res[n_res[SlotWidth-1:0]] = mk_byte(ChLowerX);
                        n_res = n_res + 1'b1;
                        do_fresh = 1'b1;
                     end
                  end
                  ESC_HEX1: begin
                     esc_in       = ESC_NONE;
                     first_hex_in = 8'd0;
                     if (is_hex(ch)) begin
                        res[n_res[SlotWidth-1:0]] = mk_byte({hex_val(first_hex_ff),
                                                             hex_val(ch)});
                        n_res = n_res + 1'b1;
                     end else begin
                        res[n_res[SlotWidth-1:0]] = mk_byte(ChLowerX);
                        n_res = n_res + 1'b1;
                        res[n_res[SlotWidth-1:0]] = mk_byte(first_hex_ff);
                        n_res = n_res + 1'b1;
                        do_fresh = 1'b1;
                     end
                  end
                  default: begin
                     do_fresh = 1'b1;
                  end
               endcase
            end
            MODE_SQ: begin
               if (esc_ff != ESC_NONE) begin
                  esc_in = ESC_NONE;
                  if (ch == ChSquote) begin
                     res[n_res[SlotWidth-1:0]] = mk_byte(ChSquote);
                     n_res = n_res + 1'b1;
                  end else begin
                     res[n_res[SlotWidth-1:0]] = mk_byte(ChBackslash);
                     n_res = n_res + 1'b1;
                     do_fresh = 1'b1;
                  end
               end else begin
                  do_fresh = 1'b1;
               end
            end
            MODE_CLOSED: begin
               if (is_sep(ch)) begin
                  res[n_res[SlotWidth-1:0]] = mk_mark(1'b1, 1'b0, 1'b0);
                  mode_in = MODE_BETWEEN;
               end else begin
                  res[n_res[SlotWidth-1:0]] = mk_mark(1'b0, 1'b0, 1'b1);
                  mode_in = MODE_ERROR;
               end
               n_res = n_res + 1'b1;
            end
            MODE_ERROR: begin
               mode_in = MODE_ERROR;
            end
            default: begin
               if (!is_sep(ch)) begin
                  mode_in  = MODE_PLAIN;
                  do_plain = 1'b1;
               end else begin
                  mode_in = MODE_BETWEEN;
               end
            end
         endcase

         // A byte inside a bare token.
         if (do_plain) begin
            if (is_sep(ch)) begin
               res[n_res[SlotWidth-1:0]] = mk_mark(1'b1, 1'b0, 1'b0);
               n_res   = n_res + 1'b1;
               mode_in = MODE_BETWEEN;
            end else if (ch == ChDquote) begin
               mode_in = MODE_DQ;
               esc_in  = ESC_NONE;
            end else if (ch == ChSquote) begin
               mode_in = MODE_SQ;
               esc_in  = ESC_NONE;
            end else begin
               res[n_res[SlotWidth-1:0]] = mk_byte(ch);
               n_res = n_res + 1'b1;
            end
         end

         // A quoted byte with no escape pending.
         if (do_fresh) begin
            if (ch == ChBackslash) begin
               esc_in = ESC_SLASH;
            end else if (ch == quote_ch) begin
               mode_in = MODE_CLOSED;
            end else begin
               res[n_res[SlotWidth-1:0]] = mk_byte(ch);
               n_res = n_res + 1'b1;
            end
         end
      end

      // The line end closes whatever is open and restarts the scan.
      if (req_tlast) begin
         case (mode_in)
            MODE_PLAIN, MODE_CLOSED: res[n_res[SlotWidth-1:0]] = mk_mark(1'b1, 1'b1, 1'b0);
            MODE_DQ, MODE_SQ:        res[n_res[SlotWidth-1:0]] = mk_mark(1'b0, 1'b1, 1'b1);
            default:                 res[n_res[SlotWidth-1:0]] = mk_mark(1'b0, 1'b1, 1'b0);
         endcase
         n_res        = n_res + 1'b1;
         mode_in      = MODE_BETWEEN;
         esc_in       = ESC_NONE;
         first_hex_in = 8'd0;
      end
   end

   // Requests that cause no result are not queued.
   assign push.valid          = accept && (n_res != '0);
   assign push.bundle.count   = n_res;
   assign push.bundle.results = res;

   // Scan state advances only on an accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BETWEEN;
         esc_ff       <= ESC_NONE;
         first_hex_ff <= 8'd0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         esc_ff       <= esc_in;
         first_hex_ff <= first_hex_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/qat_fifo.sv */
`default_nettype none

module qat_fifo #(
   parameter int DEPTH = qat_pkg::QueueDepth
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qat_pkg::qat_push_type push,
   output logic                      full,
   output qat_pkg::qat_head_type     head,
   input  wire logic                 pop
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   qat_pkg::qat_bundle_type entry_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full        = (count_ff == FullCnt);
   assign head.valid  = (count_ff != '0);
   assign head.bundle = entry_ff[rd_ptr_ff];
   assign do_push     = push.valid && !full;
   assign do_pop      = pop && head.valid;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.bundle;
      end
   end

endmodule

`default_nettype wire

/* rtl/qat_back.sv */
`default_nettype none

module qat_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qat_pkg::qat_head_type head,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int SlotWidth = $clog2(qat_pkg::MaxResults);

   logic [SlotWidth-1:0]    slot_ff, slot_in;
   logic                    out_valid_ff, out_valid_in;
   qat_pkg::qat_result_type out_ff;
   qat_pkg::qat_result_type cur;
   logic                    load;
   logic                    last_slot;

   assign cur       = head.bundle.results[slot_ff];
   assign last_slot = ({1'b0, slot_ff} + 1'b1) == head.bundle.count;
   assign load      = head.valid && (!out_valid_ff || rsp_tready);
   assign pop       = load && last_slot;

   // Walk through the head bundle one result per cycle while the output is not stalled.
   always_comb begin
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
         slot_in      = last_slot ? '0 : slot_ff + 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= cur;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.token_byte;
   assign rsp_tuser  = {out_ff.parse_error, out_ff.token_done, out_ff.token_byte_valid};
   assign rsp_tlast  = out_ff.line_done;

endmodule

`default_nettype wire

/* rtl/quoted_argument_tokenizer_core.sv */
`default_nettype none

// Channel   Direction  tdata          tuser                                  tlast
// req_      in         data_byte      byte_present                           line_end
// rsp_      out        token_byte     token_byte_valid, token_done, error    line_done
//
// One request is taken per cycle while the result queue has room; it is
// decoded in the same cycle and its results, if any, up to four, are queued
// as a bundle. Results leave at one per cycle while rsp_tready allows, from a
// registered output; the queue absorbs requests with several results.
// Reset is synchronous and active high and returns the scan to between tokens.
// A stalled result side backs up through the queue to req_tready only.

module quoted_argument_tokenizer_core #(
   parameter int QUEUE_DEPTH = qat_pkg::QueueDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte
   input  wire logic       req_tuser,   // byte_present
   input  wire logic       req_tlast,   // line_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // token_byte
   output logic [2:0]      rsp_tuser,   // token_byte_valid, token_done, parse_error
   output logic            rsp_tlast    // line_done
);

   qat_pkg::qat_push_type push;
   qat_pkg::qat_head_type head;
   logic                  queue_full;
   logic                  pop;

   // Front: accepts and decodes requests.
   qat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push)
   );

   // Queue of result bundles.
   qat_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // Back: sends the results one by one.
   qat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* dv/tokenizer_tb_pkg.sv */
`timescale 1ns / 1ps

package tokenizer_tb_pkg;

   // Scan position within one command line.
   typedef enum logic [2:0] {
      SCAN_BETWEEN,
      SCAN_PLAIN,
      SCAN_DQUOTE,
      SCAN_SQUOTE,
      SCAN_CLOSED,
      SCAN_ERROR
   } scan_mode_type;

   // Progress through a backslash sequence.
   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_SLASH,
      ESC_HEX_FIRST,
      ESC_HEX_SECOND
   } escape_stage_type;

   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharSquote    = 8'h27;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharHexMark   = 8'h78;

   function automatic bit is_separator(logic [7:0] c);
      return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09 || c == 8'h0B || c == 8'h0C;
   endfunction

   function automatic bit is_hex_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [3:0] hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
      return 4'd0;
   endfunction

   // Tracks the tokenizer scan state and holds the token results still owed.
   class tokenizer_checker;
      scan_mode_type           mode;
      escape_stage_type        esc;
      logic [7:0]              held_hex;
      qat_pkg::qat_result_type owed_results[$];
      int                      step_results;
      int                      mismatches;
      int                      byte_count;
      int                      token_count;
      int                      line_count;
      int                      error_count;

      function new();
         clear_scan();
         mismatches  = 0;
         byte_count  = 0;
         token_count = 0;
         line_count  = 0;
         error_count = 0;
      endfunction

      function void clear_scan();
         mode     = SCAN_BETWEEN;
         esc      = ESC_NONE;
         held_hex = 8'h00;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // One request never yields more than MaxResults results.
      function void owe(logic [7:0] b, bit is_byte, bit tok_end, bit line_end, bit err);
         qat_pkg::qat_result_type r;
         if (step_results >= qat_pkg::MaxResults) return;
         r.token_byte       = b;
         r.token_byte_valid = is_byte;
         r.token_done       = tok_end;
         r.line_done        = line_end;
         r.parse_error      = err;
         owed_results.insert(owed_results.size(), r);
         step_results++;
      endfunction

      function void owe_byte(logic [7:0] b);
         owe(b, 1'b1, 1'b0, 1'b0, 1'b0);
      endfunction

      // Byte inside quotes with no escape pending.
      function void quoted_fresh(logic [7:0] c, logic [7:0] closing);
         if (c == CharBackslash) esc = ESC_SLASH;
         else if (c == closing) mode = SCAN_CLOSED;
         else owe_byte(c);
      endfunction

      function void plain_char(logic [7:0] c);
         if (is_separator(c)) begin
            owe(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            mode = SCAN_BETWEEN;
         end else if (c == CharDquote) begin
            mode = SCAN_DQUOTE;
            esc  = ESC_NONE;
         end else if (c == CharSquote) begin
            mode = SCAN_SQUOTE;
            esc  = ESC_NONE;
         end else begin
            owe_byte(c);
         end
      endfunction

      function logic [7:0] control_char(logic [7:0] c);
         case (c)
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            "b": return 8'h08;
            "a": return 8'h07;
            default: return c;
         endcase
      endfunction

      // Double quotes: control escapes and two-digit hex escapes.
      function void dquote_char(logic [7:0] c);
         case (esc)
            ESC_SLASH: begin
               if (c == CharHexMark) begin
                  esc = ESC_HEX_FIRST;
               end else begin
                  esc = ESC_NONE;
                  owe_byte(control_char(c));
               end
            end
            ESC_HEX_FIRST: begin
               if (is_hex_char(c)) begin
                  held_hex = c;
                  esc      = ESC_HEX_SECOND;
               end else begin
                  esc = ESC_NONE;
                  owe_byte(CharHexMark);
                  quoted_fresh(c, CharDquote);
               end
            end
            ESC_HEX_SECOND: begin
               esc = ESC_NONE;
               if (is_hex_char(c)) begin
                  owe_byte({hex_value(held_hex), hex_value(c)});
               end else begin
                  owe_byte(CharHexMark);
                  owe_byte(held_hex);
                  quoted_fresh(c, CharDquote);
               end
               held_hex = 8'h00;
            end
            default: quoted_fresh(c, CharDquote);
         endcase
      endfunction

      // Single quotes: only an escaped quote is special.
      function void squote_char(logic [7:0] c);
         if (esc != ESC_NONE) begin
            esc = ESC_NONE;
            if (c == CharSquote) begin
               owe_byte(CharSquote);
            end else begin
               owe_byte(CharBackslash);
               quoted_fresh(c, CharSquote);
            end
         end else begin
            quoted_fresh(c, CharSquote);
         end
      endfunction

      // Works out the results owed for one accepted request.
      function void note_request(logic [7:0] c, bit present, bit last);
         step_results = 0;
         if (present) begin
            case (mode)
               SCAN_PLAIN:  plain_char(c);
               SCAN_DQUOTE: dquote_char(c);
               SCAN_SQUOTE: squote_char(c);
               SCAN_CLOSED: begin
                  if (is_separator(c)) begin
                     owe(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
                     mode = SCAN_BETWEEN;
                  end else begin
                     owe(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
                     mode = SCAN_ERROR;
                  end
               end
               SCAN_ERROR: ;
               default: begin
                  if (!is_separator(c)) begin
                     mode = SCAN_PLAIN;
                     plain_char(c);
                  end else begin
                     mode = SCAN_BETWEEN;
                  end
               end
            endcase
         end
         if (last) begin
            case (mode)
               SCAN_PLAIN, SCAN_CLOSED: owe(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
               SCAN_DQUOTE, SCAN_SQUOTE: owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
               default: owe(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
            endcase
            clear_scan();
         end
      endfunction

      // Compares one accepted result with the oldest one owed.
      function void check_result(logic [7:0] tdata, logic [2:0] tuser, logic tlast);
         qat_pkg::qat_result_type got;
         qat_pkg::qat_result_type want;
         got.token_byte       = tdata;
         got.token_byte_valid = tuser[0];
         got.token_done       = tuser[1];
         got.parse_error      = tuser[2];
         got.line_done        = tlast;
         if (got.token_byte_valid === 1'b1) byte_count++;
         if (got.token_done === 1'b1) token_count++;
         if (got.line_done === 1'b1) line_count++;
         if (got.parse_error === 1'b1) error_count++;
         if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: byte %h valid %b token_done %b line_done %b error %b",
                        got.token_byte, got.token_byte_valid, got.token_done,
                        got.line_done, got.parse_error);
            end
            return;
         end
         want = owed_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: expected byte %h valid %b token_done %b line_done %b error %b",
                        want.token_byte, want.token_byte_valid, want.token_done,
                        want.line_done, want.parse_error);
               $display("          actual   byte %h valid %b token_done %b line_done %b error %b",
                        got.token_byte, got.token_byte_valid, got.token_done,
                        got.line_done, got.parse_error);
            end
         end
      endfunction
   endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int StallLimit  = 2000;
   localparam int RandomItems = 384;
   localparam int TailCycles  = 16;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // data_byte
   logic       req_tuser;    // byte_present
   logic       req_tlast;    // line_end
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // token_byte
   logic [2:0] rsp_tuser;    // token_byte_valid, token_done, parse_error
   logic       rsp_tlast;    // line_done

   int                                 send_idle_pct;
   int                                 recv_idle_pct;
   int                                 idle_cycles;
   int                                 sent_items;
   int                                 lines_sent;
   logic [7:0]                         line_buf[$];
   tokenizer_tb_pkg::tokenizer_checker tracker;

   quoted_argument_tokenizer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The result side stalls at random at the current rate.
   always @(negedge clock) begin
      rsp_tready = !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Check each accepted result and watch for a hung handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= StallLimit) begin
               $display("Watchdog: no request or result moved for %0d cycles", StallLimit);
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   // Drives one request, with random idle cycles before it, and waits for acceptance.
   task automatic send_request(logic [7:0] c, logic present, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata  = 8'($urandom_range(255));
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = c;
      req_tuser  = present;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(c, present, last);
      if (present || last) sent_items++;
      if (last) lines_sent++;
   endtask

   // Sends the bytes in line_buf as one line, ended on the last byte or by a bare marker.
   task automatic send_line(bit bare_end);
      int i;
      if (line_buf.size() == 0) bare_end = 1'b1;
      for (i = 0; i < line_buf.size(); i++) begin
         if ($urandom_range(99) < 3) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
         send_request(line_buf[i], 1'b1, !bare_end && (i == line_buf.size() - 1));
      end
      if (bare_end) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // Appends one byte to the line being built.
   function automatic void append_byte(logic [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   task automatic load_text(string s);
      int i;
      line_buf.delete();
      for (i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_plain_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(99) < 60) c = 8'($urandom_range(126, 33));
         else c = 8'($urandom_range(255));
      end while (tokenizer_tb_pkg::is_separator(c) || c == tokenizer_tb_pkg::CharDquote ||
                 c == tokenizer_tb_pkg::CharSquote);
      return c;
   endfunction

   // Content byte for quotes: neither the closing quote nor a backslash.
   function automatic logic [7:0] rand_quoted_char(logic [7:0] closing);
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == closing || c == tokenizer_tb_pkg::CharBackslash);
      return c;
   endfunction

   function automatic logic [7:0] rand_hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(21)];
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (tokenizer_tb_pkg::is_hex_char(c));
      return c;
   endfunction

   function automatic logic [7:0] rand_separator();
      case ($urandom_range(5))
         0: return 8'h09;
         1: return 8'h0A;
         2: return 8'h0B;
         3: return 8'h0C;
         4: return 8'h0D;
         default: return 8'h20;
      endcase
   endfunction

   // Double-quoted part with plain content and every escape form.
   function automatic void add_dquoted();
      int n;
      int k;
      string controls;
      controls = "nrtba";
      append_byte(tokenizer_tb_pkg::CharDquote);
      n = $urandom_range(4);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(99) < 50) begin
            append_byte(rand_quoted_char(tokenizer_tb_pkg::CharDquote));
         end else begin
            append_byte(tokenizer_tb_pkg::CharBackslash);
            case ($urandom_range(5))
               0: append_byte(controls[$urandom_range(4)]);
               1, 2: begin
                  append_byte(tokenizer_tb_pkg::CharHexMark);
                  append_byte(rand_hex_char());
                  append_byte(rand_hex_char());
               end
               3: begin
                  append_byte(tokenizer_tb_pkg::CharHexMark);
                  append_byte(rand_hex_char());
                  append_byte(rand_non_hex());
               end
               4: begin
                  append_byte(tokenizer_tb_pkg::CharHexMark);
                  append_byte(rand_non_hex());
               end
               default: append_byte(8'($urandom_range(255)));
            endcase
         end
      end
      if ($urandom_range(99) < 92) append_byte(tokenizer_tb_pkg::CharDquote);
   endfunction

   // Single-quoted part with escaped quotes and lone backslashes.
   function automatic void add_squoted();
      int n;
      int k;
      append_byte(tokenizer_tb_pkg::CharSquote);
      n = $urandom_range(4);
      for (k = 0; k < n; k++) begin
         case ($urandom_range(3))
            0: begin
               append_byte(tokenizer_tb_pkg::CharBackslash);
               append_byte(tokenizer_tb_pkg::CharSquote);
            end
            1: begin
               append_byte(tokenizer_tb_pkg::CharBackslash);
               append_byte(8'($urandom_range(255)));
            end
            default: append_byte(rand_quoted_char(tokenizer_tb_pkg::CharSquote));
         endcase
      end
      if ($urandom_range(99) < 92) append_byte(tokenizer_tb_pkg::CharSquote);
   endfunction

   // Builds a random line in line_buf: mostly well-formed tokens, some raw noise.
   task automatic build_random_line(output bit bare_end);
      int ntok;
      int t;
      int p;
      int k;
      line_buf.delete();
      bare_end = ($urandom_range(99) < 30);
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(10, 1)) append_byte(8'($urandom_range(255)));
         return;
      end
      ntok = $urandom_range(4);
      if ($urandom_range(99) < 30) append_byte(rand_separator());
      for (t = 0; t < ntok; t++) begin
         for (p = 0; p < $urandom_range(3, 1); p++) begin
            case ($urandom_range(2))
               0: for (k = 0; k < $urandom_range(4, 1); k++) append_byte(rand_plain_char());
               1: add_dquoted();
               default: add_squoted();
            endcase
            // A byte right after a closing quote is an error, so keep it rare.
            if ((line_buf[$] == tokenizer_tb_pkg::CharDquote ||
                 line_buf[$] == tokenizer_tb_pkg::CharSquote) &&
                $urandom_range(99) < 85) break;
         end
         if (t < ntok - 1 || $urandom_range(99) < 30) begin
            repeat ($urandom_range(2, 1)) append_byte(rand_separator());
         end
      end
   endtask

   // Reset, directed lines, then three random phases with different stall rates.
   initial begin
      int phase;
      int target;
      bit bare_end;
      tracker       = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      idle_cycles   = 0;
      sent_items    = 0;
      lines_sent    = 0;
      send_idle_pct = 26;
      recv_idle_pct = 65;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty item, empty line, extreme bytes, escapes and the error cases.
      send_request(8'h00, 1'b0, 1'b0);
      send_request(8'hFF, 1'b0, 1'b1);
      line_buf = '{8'hFF, 8'h00};
      send_line(1'b0);
      load_text("\"\\x4a\\xg\"");
      send_line(1'b0);
      load_text("'\\'\\b");
      send_line(1'b0);
      load_text("\"\\n\\");
      send_line(1'b0);
      load_text("\"a\"bc");
      send_line(1'b1);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         target = sent_items + RandomItems / 3;
         while (sent_items < target) begin
            build_random_line(bare_end);
            send_line(bare_end);
         end
         // Hold the request side off until every owed result has come back.
         @(negedge clock);
         req_tvalid = 1'b0;
         while (tracker.pending() != 0) @(negedge clock);
      end

      repeat (TailCycles) @(posedge clock);
      $display("Sent %0d requests in %0d lines at three stall mixes.", sent_items, lines_sent);
      $display("Seen %0d token bytes, %0d token ends, %0d line ends, %0d parse errors.",
               tracker.byte_count, tracker.token_count, tracker.line_count,
               tracker.error_count);
      if (tracker.pending() != 0) $display("%0d expected results never arrived", tracker.pending());
      if (tracker.mismatches != 0) $display("%0d result mismatches", tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
